// ----- rtl/alw_pkg.sv -----
// Shared types and constants of the antialiased line rasterizer.
package alw_pkg;

  localparam int unsigned CoordIntBits  = 12;
  localparam int unsigned CoordFracBits = 4;
  localparam int unsigned GradFracBits  = 16;
  localparam int unsigned CoordW        = CoordIntBits + CoordFracBits;
  localparam int unsigned MinorW        = CoordIntBits + GradFracBits;
  localparam int unsigned GradW         = GradFracBits + 2;
  localparam int unsigned GapW          = CoordFracBits + 1;
  localparam int unsigned PixW          = 12;
  localparam int unsigned AlphaW        = 8;
  localparam int unsigned InDataW       = 4 * CoordW;
  localparam int unsigned OutDataW      = 2 * PixW + 2 * AlphaW;

  localparam logic KindLoad = 1'b0;
  localparam logic KindStep = 1'b1;

  typedef struct packed {
    logic              is_load;
    logic              swapped;
    logic [CoordW-1:0] a1;
    logic [CoordW-1:0] m1;
    logic [CoordW-1:0] a2;
    logic [CoordW-1:0] m2;
  } cmd_t;

endpackage

// ----- rtl/antialiased_line_wu.sv -----
// Top level of the fixed-point antialiased line rasterizer.
//
// Usage: send a load item (s_axis_tuser = 0) with two endpoints in unsigned
// 12.4 fixed point, then one step item (s_axis_tuser = 1) per pixel pair.
// Each step of an active line returns one item on the master side: the
// start endpoint pair, the interior pairs, then the end pair with tlast set.
// Steps with no active line are consumed and return nothing.
// A step item passes the input stage register and a queue entry before the
// core registers its result. Steps sustain one item per cycle while the
// receiver takes results and no load occupies the core.
// A load occupies the core for the gradient divider, one quotient bit per
// cycle, then the setup state; a zero major span skips the divider.
// Items accepted behind a load wait in the two-entry queue and input stage.
// Reset clears all control state; no line is active afterwards.
// When the receiver stalls, hold the result in the output register; the
// input side keeps taking items until the queue and input stage fill.
module antialiased_line_wu import alw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // x_start, y_start, x_end, y_end
  input  logic                s_axis_tuser,  // kind
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // pixel_x, pixel_y, alpha_near, alpha_far
  output logic                m_axis_tuser,  // steep
  output logic                m_axis_tlast   // last
);

  logic fr_valid, fr_ready, q_valid, q_pop;
  cmd_t fr_cmd, q_cmd;

  // classify and order endpoints
  alw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .kind_i      (s_axis_tuser),
    .data_i      (s_axis_tdata),
    .cmd_valid_o (fr_valid),
    .cmd_ready_i (fr_ready),
    .cmd_o       (fr_cmd)
  );

  // decouple the input stage from long loads in the core
  alw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_cmd_i   (fr_cmd),
    .pop_valid_o  (q_valid),
    .pop_i        (q_pop),
    .pop_cmd_o    (q_cmd)
  );

  // divide, set up endpoints, step pairs
  alw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_i       (q_cmd),
    .cmd_pop_o   (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_steep_o (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

// ----- rtl/alw_front.sv -----
// Input stage: accept items, pick the major axis and order the endpoints.
module alw_front import alw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [InDataW-1:0] data_i,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i,
  output cmd_t               cmd_o
);

  logic              valid_q, valid_d;
  cmd_t              cmd_q;
  cmd_t              cmd_d;
  logic [CoordW-1:0] xa, ya, xb, yb, a1, m1, a2, m2;
  logic [CoordW:0]   dx, dy, adx, ady;
  logic              swap;

  assign xa = data_i[CoordW-1:0];
  assign ya = data_i[2*CoordW-1:CoordW];
  assign xb = data_i[3*CoordW-1:2*CoordW];
  assign yb = data_i[4*CoordW-1:3*CoordW];

  always_comb begin
    dx   = {1'b0, xb} - {1'b0, xa};
    dy   = {1'b0, yb} - {1'b0, ya};
    adx  = dx[CoordW] ? (~dx + 1'b1) : dx;
    ady  = dy[CoordW] ? (~dy + 1'b1) : dy;
    swap = adx < ady;
    a1   = swap ? ya : xa;
    m1   = swap ? xa : ya;
    a2   = swap ? yb : xb;
    m2   = swap ? xb : yb;
    cmd_d.is_load = (kind_i == KindLoad);
    cmd_d.swapped = swap;
    // put the smaller major coordinate first
    if (a1 > a2) begin
      cmd_d.a1 = a2;
      cmd_d.m1 = m2;
      cmd_d.a2 = a1;
      cmd_d.m2 = m1;
    end else begin
      cmd_d.a1 = a1;
      cmd_d.m1 = m1;
      cmd_d.a2 = a2;
      cmd_d.m2 = m2;
    end
  end

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

// ----- rtl/alw_queue.sv -----
// Two-entry command queue between the input stage and the rasterizer core.
module alw_queue import alw_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output cmd_t pop_cmd_o
);

  cmd_t       mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = mem_q[rptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wptr_d  = wptr_q ^ push;
    rptr_d  = rptr_q ^ pop;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- rtl/alw_back.sv -----
// Rasterizer core: gradient division, endpoint setup and pixel pair stepping.
module alw_back import alw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cmd_t                cmd_i,
  output logic                cmd_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [OutDataW-1:0] out_data_o,
  output logic                out_steep_o,
  output logic                out_last_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  localparam logic [1:0] PhStart = 2'd0;
  localparam logic [1:0] PhMid   = 2'd1;
  localparam logic [1:0] PhEnd   = 2'd2;

  localparam int unsigned NumW = CoordW + GradFracBits;
  localparam int unsigned CntW = $clog2(NumW);
  localparam int unsigned QuoW = GradFracBits + 1;
  localparam int unsigned ProdW = GradW + GapW;
  localparam logic [GapW-1:0] GapOne = GapW'(1 << CoordFracBits);
  localparam logic [GradW-1:0] GradOne = GradW'(1 << GradFracBits);

  logic [1:0]             st_q, st_d, phase_q, phase_d;
  logic                   active_q, active_d, swapped_q, swapped_d;
  logic [CoordIntBits-1:0] major_pos_q, major_pos_d, major_last_q, major_last_d;
  logic [MinorW-1:0]      accum_q, accum_d, smin_q, smin_d, emin_q, emin_d;
  logic [GapW-1:0]        sgap_q, sgap_d, egap_q, egap_d;
  logic [GradW-1:0]       grad_q, grad_d;
  logic [CoordW-1:0]      a1_q, a1_d, m1_q, m1_d, a2_q, a2_d, m2_q, m2_d;
  logic                   neg_q, neg_d;
  logic [CoordW-1:0]      dmaj_q, dmaj_d;
  logic [NumW-1:0]        num_q, num_d;
  logic [CoordW-1:0]      rem_q, rem_d;
  logic [QuoW-1:0]        quo_q, quo_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  logic                   ov_q, ov_d, olast_q, olast_d, osteep_q, osteep_d;
  logic [OutDataW-1:0]    odata_q, odata_d;

  // divider step
  logic [CoordW:0]        rs;
  logic                   ge;
  // load setup
  logic [CoordW:0]        dmin;
  logic [CoordW-1:0]      dmaj;
  // emit
  logic                   emit;
  logic [CoordIntBits-1:0] e_maj;
  logic [MinorW-1:0]      e_mnr;
  logic [GapW-1:0]        e_gap;
  logic                   e_fin;

  function automatic logic [CoordIntBits-1:0] round_major(logic [CoordW-1:0] c);
    logic [CoordW:0] s;
    s = {1'b0, c} + (CoordW+1)'(1 << (CoordFracBits - 1));
    if (s[CoordW:CoordFracBits] > (CoordIntBits+1)'({CoordIntBits{1'b1}})) begin
      return {CoordIntBits{1'b1}};
    end
    return s[CoordIntBits+CoordFracBits-1:CoordFracBits];
  endfunction

  function automatic logic [MinorW-1:0] minor_at(logic [CoordIntBits-1:0] col,
                                                 logic [CoordW-1:0] maj,
                                                 logic [CoordW-1:0] mnr,
                                                 logic [GradW-1:0] grad);
    logic signed [CoordW+1:0] diff;
    logic signed [GapW-1:0]   d;
    logic signed [ProdW-1:0]  p;
    logic signed [ProdW-1:0]  sh;
    diff = $signed({2'b00, col, {CoordFracBits{1'b0}}}) - $signed({2'b00, maj});
    d    = diff[GapW-1:0];
    p    = $signed(grad) * d;
    sh   = p >>> CoordFracBits;
    return {mnr, {(GradFracBits-CoordFracBits){1'b0}}}
           + MinorW'({{(MinorW-ProdW){sh[ProdW-1]}}, sh});
  endfunction

  function automatic logic [AlphaW-1:0] alpha(logic [QuoW-1:0] fr, logic [GapW-1:0] gap);
    logic [QuoW+GapW-1:0]   t;
    logic [QuoW+GapW+7:0]   s;
    t = fr * gap;
    s = {t, 8'd0} - {8'd0, t};
    return s[GradFracBits+CoordFracBits+AlphaW-1:GradFracBits+CoordFracBits];
  endfunction

  assign rs   = {rem_q, num_q[NumW-1]};
  assign ge   = rs >= {1'b0, dmaj_q};
  assign dmaj = cmd_i.a2 - cmd_i.a1;
  assign dmin = {1'b0, cmd_i.m2} - {1'b0, cmd_i.m1};

  always_comb begin
    st_d = st_q; phase_d = phase_q; active_d = active_q; swapped_d = swapped_q;
    major_pos_d = major_pos_q; major_last_d = major_last_q;
    accum_d = accum_q; smin_d = smin_q; emin_d = emin_q;
    sgap_d = sgap_q; egap_d = egap_q; grad_d = grad_q;
    a1_d = a1_q; m1_d = m1_q; a2_d = a2_q; m2_d = m2_q;
    neg_d = neg_q; dmaj_d = dmaj_q; num_d = num_q; rem_d = rem_q;
    quo_d = quo_q; cnt_d = cnt_q;
    cmd_pop_o = 1'b0;
    emit  = 1'b0;
    e_maj = major_pos_q; e_mnr = smin_q; e_gap = sgap_q; e_fin = 1'b0;

    unique case (st_q)
      StIdle: begin
        if (cmd_valid_i && cmd_i.is_load) begin
          cmd_pop_o = 1'b1;
          active_d  = 1'b0;
          swapped_d = cmd_i.swapped;
          a1_d = cmd_i.a1; m1_d = cmd_i.m1; a2_d = cmd_i.a2; m2_d = cmd_i.m2;
          neg_d  = dmin[CoordW];
          dmaj_d = dmaj;
          num_d  = {(dmin[CoordW] ? CoordW'(~dmin + 1'b1) : dmin[CoordW-1:0]),
                    {GradFracBits{1'b0}}};
          rem_d  = '0;
          quo_d  = '0;
          cnt_d  = '0;
          if (dmaj == '0) begin
            grad_d = GradOne;
            st_d   = StFin;
          end else begin
            st_d = StDiv;
          end
        end else if (cmd_valid_i && (!ov_q || out_ready_i)) begin
          cmd_pop_o = 1'b1;
          if (active_q) begin
            unique case (phase_q)
              PhStart: begin
                emit = 1'b1;
                if ({1'b0, major_last_q} >= {1'b0, major_pos_q} + 2'd2) begin
                  major_pos_d = major_pos_q + 1'b1;
                  phase_d     = PhMid;
                end else begin
                  phase_d = PhEnd;
                end
              end
              PhMid: begin
                emit  = 1'b1;
                e_mnr = accum_q;
                e_gap = GapOne;
                accum_d = accum_q + MinorW'({{(MinorW-GradW){grad_q[GradW-1]}}, grad_q});
                if ({1'b0, major_pos_q} + 1'b1 >= {1'b0, major_last_q}) begin
                  phase_d = PhEnd;
                end else begin
                  major_pos_d = major_pos_q + 1'b1;
                end
              end
              PhEnd: begin
                emit  = 1'b1;
                e_maj = major_last_q;
                e_mnr = emin_q;
                e_gap = egap_q;
                e_fin = 1'b1;
                active_d = 1'b0;
                phase_d  = PhStart;
              end
              default: begin
                active_d = 1'b0;
                phase_d  = PhStart;
              end
            endcase
          end
        end
      end
      StDiv: begin
        rem_d = ge ? CoordW'(rs - {1'b0, dmaj_q}) : rs[CoordW-1:0];
        num_d = {num_q[NumW-2:0], 1'b0};
        quo_d = {quo_q[QuoW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          grad_d = neg_q ? (~{1'b0, quo_d} + 1'b1) : {1'b0, quo_d};
          st_d   = StFin;
        end
      end
      StFin: begin
        major_pos_d  = round_major(a1_q);
        major_last_d = round_major(a2_q);
        smin_d = minor_at(major_pos_d, a1_q, m1_q, grad_q);
        emin_d = minor_at(major_last_d, a2_q, m2_q, grad_q);
        sgap_d = GapOne - {1'b0, a1_q[CoordFracBits-1:0]
                                 + CoordFracBits'(1 << (CoordFracBits - 1))};
        egap_d = {1'b0, a2_q[CoordFracBits-1:0] + CoordFracBits'(1 << (CoordFracBits - 1))};
        accum_d  = smin_d + MinorW'({{(MinorW-GradW){grad_q[GradW-1]}}, grad_q});
        phase_d  = PhStart;
        active_d = 1'b1;
        st_d     = StIdle;
      end
      default: st_d = StIdle;
    endcase
  end

  // output register
  always_comb begin
    logic [CoordIntBits-1:0] mi;
    logic [QuoW-1:0]         f, rf;
    logic [PixW-1:0]         px, py;
    mi = e_mnr[MinorW-1:GradFracBits];
    f  = {1'b0, e_mnr[GradFracBits-1:0]};
    rf = QuoW'(1 << GradFracBits) - f;
    px = PixW'(swapped_q ? mi : e_maj);
    py = PixW'(swapped_q ? e_maj : mi);
    ov_d = ov_q && !out_ready_i;
    odata_d = odata_q; olast_d = olast_q; osteep_d = osteep_q;
    if (emit) begin
      ov_d     = 1'b1;
      odata_d  = {alpha(f, e_gap), alpha(rf, e_gap), py, px};
      olast_d  = e_fin;
      osteep_d = swapped_q;
    end
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = odata_q;
  assign out_last_o  = olast_q;
  assign out_steep_o = osteep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; phase_q <= PhStart; active_q <= 1'b0; swapped_q <= 1'b0;
      major_pos_q <= '0; major_last_q <= '0; accum_q <= '0; grad_q <= '0;
      smin_q <= '0; emin_q <= '0; sgap_q <= '0; egap_q <= '0;
      cnt_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; phase_q <= phase_d; active_q <= active_d; swapped_q <= swapped_d;
      major_pos_q <= major_pos_d; major_last_q <= major_last_d; accum_q <= accum_d;
      grad_q <= grad_d; smin_q <= smin_d; emin_q <= emin_d;
      sgap_q <= sgap_d; egap_q <= egap_d; cnt_q <= cnt_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= a1_d; m1_q <= m1_d; a2_q <= a2_d; m2_q <= m2_d;
    neg_q <= neg_d; dmaj_q <= dmaj_d; num_q <= num_d; rem_q <= rem_d; quo_q <= quo_d;
    odata_q <= odata_d; olast_q <= olast_d; osteep_q <= osteep_d;
  end

endmodule

// ----- rtl/alw_checker.sv -----
// Port-level assertions for the antialiased line rasterizer.
module alw_checker import alw_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tuser,
  input logic                m_axis_tlast
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // two coverages of one pair never exceed full scale
  a_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ({1'b0, m_axis_tdata[2*PixW+AlphaW-1:2*PixW]}
      + {1'b0, m_axis_tdata[OutDataW-1:2*PixW+AlphaW]}) <= 9'd255)
    else $error("alpha sum above 255");

  // no result right after reset
  a_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result valid out of reset");

endmodule

bind antialiased_line_wu alw_checker u_alw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
